FILE: src/assert_macros.svh
// Assertion macros shared by the slice view calculator RTL.
// Depends on a clock named clock and a synchronous reset named reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SVC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Check that a condition never holds outside reset.
`define SVC_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

FILE: src/svc_pkg.sv
// Types and constants for the slice view calculator.
// No dependencies; every other source file but assert_macros.svh imports it.
`timescale 1ns / 1ps
`default_nettype none

package svc_pkg;

   // One restoring divide cell per quotient bit of the length.
   localparam int DIV_CELLS = 31;

   typedef enum logic [1:0] {
      ERR_OK        = 2'd0,
      ERR_STEP_ZERO = 2'd1,
      ERR_OVERFLOW  = 2'd2
   } err_type;

   typedef struct packed {
      logic               start_given;
      logic signed [31:0] start_value;
      logic               stop_given;
      logic signed [31:0] stop_value;
      logic signed [31:0] step_value;
      logic [30:0]        dim_len;
      logic signed [31:0] in_stride;
      logic signed [47:0] base_offset;
   } svc_req_type;

   typedef struct packed {
      logic [1:0]         error_code;
      logic signed [31:0] norm_start;
      logic [30:0]        out_length;
      logic signed [63:0] out_stride;
      logic signed [47:0] out_offset;
   } svc_rsp_type;

   // Fields that ride along the divide chain untouched.
   typedef struct packed {
      logic signed [31:0] start;
      logic signed [31:0] stride;
      logic signed [31:0] step;
      logic signed [47:0] base;
      logic               empty;
      logic               step_zero;
   } svc_side_type;

   // One beat inside the divide chain: partial remainder, dividend/quotient
   // shift word, divisor magnitude and the sideband.
   typedef struct packed {
      logic [30:0]  rem;
      logic [30:0]  dq;
      logic [31:0]  divisor;
      svc_side_type side;
   } svc_div_type;

endpackage

`default_nettype wire

FILE: src/svc_if.sv
// Valid/ready channel interfaces for slice requests and view results.
// Depends on svc_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface svc_req_if;
   import svc_pkg::*;
   logic        valid;
   logic        ready;
   svc_req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface svc_rsp_if;
   import svc_pkg::*;
   logic        valid;
   logic        ready;
   svc_rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/svc_norm.sv
// Three-stage front end: default and wrap, clamp, then length numerator.
// Depends on svc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module svc_norm (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  svc_pkg::svc_req_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output svc_pkg::svc_div_type out_data
);
   import svc_pkg::*;

   typedef struct packed {
      logic signed [31:0] start;
      logic signed [31:0] stop;
      logic signed [31:0] hi;
      logic               pos;
      logic [31:0]        divisor;
      svc_side_type       side;
   } svc_bound_type;

   logic          va_ff, vb_ff, vc_ff;
   logic          adv_a, adv_b, adv_c;
   svc_bound_type a_ff, a_in;
   svc_bound_type b_ff, b_in;
   svc_div_type   c_ff, c_in;
   logic signed [31:0] d32;
   logic signed [31:0] lo;
   logic signed [32:0] num;
   logic signed [31:0] hi_val;
   logic signed [31:0] lo_val;

   assign adv_c    = !vc_ff || out_ready;
   assign adv_b    = !vb_ff || adv_c;
   assign adv_a    = !va_ff || adv_b;
   assign in_ready = adv_a;

   assign out_valid = vc_ff;
   assign out_data  = c_ff;

   assign d32 = signed'({1'b0, in_data.dim_len});

   // Stage A: pick defaults, wrap given negative indices by the size.
   always_comb begin
      a_in.pos = !in_data.step_value[31];
      if (in_data.start_given) begin
         a_in.start = in_data.start_value[31] ? in_data.start_value + d32
                                              : in_data.start_value;
      end else begin
         a_in.start = a_in.pos ? 32'sd0 : d32 - 32'sd1;
      end
      if (in_data.stop_given) begin
         a_in.stop = in_data.stop_value[31] ? in_data.stop_value + d32
                                            : in_data.stop_value;
      end else begin
         a_in.stop = a_in.pos ? d32 : -32'sd1;
      end
      a_in.hi             = a_in.pos ? d32 : d32 - 32'sd1;
      a_in.divisor        = a_in.pos ? in_data.step_value : -in_data.step_value;
      a_in.side.start     = '0;
      a_in.side.stride    = in_data.in_stride;
      a_in.side.step      = in_data.step_value;
      a_in.side.base      = in_data.base_offset;
      a_in.side.empty     = 1'b0;
      a_in.side.step_zero = (in_data.step_value == 32'sd0);
   end

   // Stage B: clamp both ends to the legal window for the step direction.
   assign lo = a_ff.pos ? 32'sd0 : -32'sd1;

   always_comb begin
      b_in = a_ff;
      if (a_ff.start < lo) begin
         b_in.start = lo;
      end else if (a_ff.start > a_ff.hi) begin
         b_in.start = a_ff.hi;
      end
      if (a_ff.stop < lo) begin
         b_in.stop = lo;
      end else if (a_ff.stop > a_ff.hi) begin
         b_in.stop = a_ff.hi;
      end
   end

   // Stage C: numerator of the length division, far end minus near end less one.
   assign hi_val = b_ff.pos ? b_ff.stop : b_ff.start;
   assign lo_val = b_ff.pos ? b_ff.start : b_ff.stop;
   assign num    = 33'(hi_val) - 33'(lo_val) - 33'sd1;

   always_comb begin
      c_in.rem        = '0;
      c_in.dq         = num[30:0];
      c_in.divisor    = b_ff.divisor;
      c_in.side       = b_ff.side;
      c_in.side.start = b_ff.start;
      c_in.side.empty = num[32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         if (adv_a) va_ff <= in_valid;
         if (adv_b) vb_ff <= va_ff;
         if (adv_c) vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_a) a_ff <= a_in;
      if (adv_b) b_ff <= b_in;
      if (adv_c) c_ff <= c_in;
   end

endmodule

`default_nettype wire

FILE: src/svc_div_cell.sv
// One restoring divide cell: resolves a single quotient bit per beat.
// Depends on svc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module svc_div_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  svc_pkg::svc_div_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output svc_pkg::svc_div_type out_data
);
   import svc_pkg::*;

   logic        valid_ff;
   logic        adv;
   svc_div_type data_ff, data_in;
   logic [31:0] trial;
   logic        take;

   assign adv       = !valid_ff || out_ready;
   assign in_ready  = adv;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // Shift the next dividend bit into the remainder, subtract if it fits.
   assign trial = {in_data.rem, in_data.dq[30]};
   assign take  = (trial >= in_data.divisor);

   always_comb begin
      data_in     = in_data;
      data_in.rem = take ? 31'(trial - in_data.divisor) : trial[30:0];
      data_in.dq  = {in_data.dq[29:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) data_ff <= data_in;
   end

   `SVC_ASSERT(a_rem_below_divisor,
      valid_ff && !data_ff.side.step_zero |-> {1'b0, data_ff.rem} < data_ff.divisor,
      "partial remainder not below divisor")

endmodule

`default_nettype wire

FILE: src/svc_fin.sv
// Back end: products and length, then offset add, overflow check, result register.
// Depends on svc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module svc_fin (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  svc_pkg::svc_div_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output svc_pkg::svc_rsp_type out_data
);
   import svc_pkg::*;

   typedef struct packed {
      logic [30:0]        len;
      logic signed [63:0] sprod;
      logic signed [63:0] oprod;
      logic signed [31:0] start;
      logic signed [47:0] base;
      logic               empty;
      logic               step_zero;
   } svc_prod_type;

   logic               v1_ff, v2_ff;
   logic               adv1, adv2;
   svc_prod_type       p_ff, p_in;
   svc_rsp_type        r_ff, r_in;
   logic signed [63:0] off_sum;
   logic               ovf;

   assign adv2      = !v2_ff || out_ready;
   assign adv1      = !v1_ff || adv2;
   assign in_ready  = adv1;
   assign out_valid = v2_ff;
   assign out_data  = r_ff;

   // Stage 1: both multiplies in parallel, length from the quotient.
   always_comb begin
      p_in.len       = in_data.side.empty ? 31'd0 : in_data.dq + 31'd1;
      p_in.sprod     = 64'(in_data.side.stride) * 64'(in_data.side.step);
      p_in.oprod     = 64'(in_data.side.start) * 64'(in_data.side.stride);
      p_in.start     = in_data.side.start;
      p_in.base      = in_data.side.base;
      p_in.empty     = in_data.side.empty;
      p_in.step_zero = in_data.side.step_zero;
   end

   // Stage 2: add the base and check the 48-bit range.
   assign off_sum = 64'(p_ff.base) + p_ff.oprod;
   assign ovf     = (off_sum[63:47] != {17{off_sum[47]}});

   always_comb begin
      r_in = '0;
      if (p_ff.step_zero) begin
         r_in.error_code = ERR_STEP_ZERO;
      end else if (p_ff.empty) begin
         r_in.error_code = ERR_OK;
         r_in.norm_start = p_ff.start;
         r_in.out_stride = 64'sd1;
         r_in.out_offset = p_ff.base;
      end else if (ovf) begin
         r_in.error_code = ERR_OVERFLOW;
      end else begin
         r_in.error_code = ERR_OK;
         r_in.norm_start = p_ff.start;
         r_in.out_length = p_ff.len;
         r_in.out_stride = p_ff.sprod;
         r_in.out_offset = off_sum[47:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= in_valid;
         if (adv2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) p_ff <= p_in;
      if (adv2) r_ff <= r_in;
   end

   `SVC_ASSERT(a_error_zeroes_fields,
      v2_ff && (r_ff.error_code != ERR_OK) |-> (r_ff.norm_start == 32'sd0)
         && (r_ff.out_length == 31'd0) && (r_ff.out_stride == 64'sd0)
         && (r_ff.out_offset == 48'sd0),
      "error result carries nonzero fields")
   `SVC_ASSERT(a_empty_unit_stride,
      v2_ff && (r_ff.error_code == ERR_OK) && (r_ff.out_length == 31'd0)
         |-> (r_ff.out_stride == 64'sd1),
      "empty slice without unit stride")

endmodule

`default_nettype wire

FILE: src/slice_view_calc.sv
// Slice view calculator: a request beat passes through 3 normalize stages,
// 31 divide cells and 2 product/offset stages on its way to a result beat.
// Throughput is one slice per cycle while the result side stays ready; each stage stalls only when full and
// its downstream neighbor is full and stalled, so ready ripples up the chain.
// Synchronous active-high reset clears every stage valid bit; payload
// registers are not reset. Results come out in request order.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module slice_view_calc (
   input  logic      clock,
   input  logic      reset,
   svc_req_if.sink   req_chan,
   svc_rsp_if.source rsp_chan
);
   import svc_pkg::*;

   // Chain taps: index 0 is the front end output, DIV_CELLS is the last cell.
   logic        chain_valid [DIV_CELLS+1];
   logic        chain_ready [DIV_CELLS+1];
   svc_div_type chain_data  [DIV_CELLS+1];

   // Front end: defaults, wrap of negative indices, clamp, numerator and
   // divisor magnitude for the length division.
   svc_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_data   (req_chan.data),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   // Divide chain: each cell resolves one quotient bit, most significant
   // first, and hands the shifted remainder to its neighbor.
   for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
      svc_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   // Back end: length, stride product, offset product and add, overflow
   // check and the result register that drives the response channel.
   svc_fin u_fin (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[DIV_CELLS]),
      .in_ready  (chain_ready[DIV_CELLS]),
      .in_data   (chain_data[DIV_CELLS]),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (rsp_chan.data)
   );

   // Backpressure reaches the request side only when the whole chain is full.
   `SVC_ASSERT(a_stall_only_when_full,
      !req_chan.ready |-> rsp_chan.valid && !rsp_chan.ready,
      "request stalled while result side can drain")

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking bench for slice_view_calc: drives slice requests, predicts each view result.
// Depends on svc_pkg, the svc_req_if/svc_rsp_if channels and the slice_view_calc RTL.
`timescale 1ns / 1ps

module tb_top;
   import svc_pkg::*;

   // Idle stretch after the last expected result, with margin above the request-to-result path.
   localparam int DRAIN_CYCLES = 48;
   // A cycle window with no beat on either channel; far above any legal stall.
   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_SLICES = 1500;
   localparam int PRINT_CAP    = 40;

   localparam longint OFFSET_MAX = 64'sd140737488355327;
   localparam longint OFFSET_MIN = -64'sd140737488355328;

   logic clock;
   logic reset;

   svc_req_if req_bus ();
   svc_rsp_if rsp_bus ();

   slice_view_calc dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus.sink),
      .rsp_chan (rsp_bus.source)
   );

   // Expected views, oldest first, one per accepted request beat.
   svc_rsp_type expected_views[$];
   int          error_count;
   int          result_index;
   int          quiet_cycles;
   int          rsp_hold;
   // When set, neither side inserts gaps: back-to-back beats at full rate.
   bit          steady_flow;

   initial begin
      clock = 1'b0;
   end
   always #5 clock = ~clock;

   // Print one mismatch line (up to a cap) and count it.
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (error_count < PRINT_CAP)
         $display("tb_top: result %0d %s: got %h expected %h", result_index, what, got, want);
      error_count++;
   endtask

   // Work out the view that one slice request should produce.
   function automatic svc_rsp_type predict_view(input svc_req_type r);
      longint step_l, dim_l, first, last, count, stride_l, base_l, offset_l;
      svc_rsp_type v;
      v        = '0;
      step_l   = longint'($signed(r.step_value));
      dim_l    = longint'({33'd0, r.dim_len});
      stride_l = longint'($signed(r.in_stride));
      base_l   = longint'($signed(r.base_offset));
      if (step_l == 0) begin
         v.error_code = ERR_STEP_ZERO;
         return v;
      end
      if (step_l > 0) begin
         // Forward walk: wrap negatives once, then clamp into 0..size.
         first = r.start_given ? longint'($signed(r.start_value)) : 64'sd0;
         if (first < 0) first += dim_l;
         if (first < 0) first = 0;
         if (first > dim_l) first = dim_l;
         last = r.stop_given ? longint'($signed(r.stop_value)) : dim_l;
         if (last < 0) last += dim_l;
         if (last < 0) last = 0;
         if (last > dim_l) last = dim_l;
         count = (last <= first) ? 64'sd0 : (last - first + step_l - 1) / step_l;
      end else begin
         // Backward walk: defaults run from the last element past index 0,
         // clamp into -1..size-1.
         if (r.start_given) begin
            first = longint'($signed(r.start_value));
            if (first < 0) first += dim_l;
         end else begin
            first = dim_l - 1;
         end
         if (first < -1) first = -1;
         if (first > dim_l - 1) first = dim_l - 1;
         if (r.stop_given) begin
            last = longint'($signed(r.stop_value));
            if (last < 0) last += dim_l;
         end else begin
            last = -1;
         end
         if (last < -1) last = -1;
         if (last > dim_l - 1) last = dim_l - 1;
         count = (first <= last) ? 64'sd0 : (first - last - 1) / (-step_l) + 1;
      end
      v.norm_start = first[31:0];
      v.out_length = count[30:0];
      if (count == 0) begin
         // Empty view: unit stride, offset untouched.
         v.out_stride = 64'sd1;
         v.out_offset = r.base_offset;
         return v;
      end
      offset_l = base_l + first * stride_l;
      if (offset_l < OFFSET_MIN || offset_l > OFFSET_MAX) begin
         v            = '0;
         v.error_code = ERR_OVERFLOW;
         return v;
      end
      v.out_stride = stride_l * step_l;
      v.out_offset = offset_l[47:0];
      return v;
   endfunction

   function automatic svc_req_type slice_of(input logic sg, input logic [31:0] sv,
                                            input logic pg, input logic [31:0] pv,
                                            input logic [31:0] step, input logic [30:0] dim,
                                            input logic [31:0] stride,
                                            input logic [47:0] base);
      svc_req_type r;
      r.start_given = sg;
      r.start_value = sv;
      r.stop_given  = pg;
      r.stop_value  = pv;
      r.step_value  = step;
      r.dim_len     = dim;
      r.in_stride   = stride;
      r.base_offset = base;
      return r;
   endfunction

   // Index near the dimension: below -size, inside, and past the end; now and
   // then any 32-bit value.
   function automatic logic [31:0] pick_index(input int dim);
      longint idx;
      if ($urandom_range(0, 5) == 0)
         return $urandom;
      idx = longint'($urandom_range(0, 2 * dim + 4)) - longint'(dim + 2);
      return idx[31:0];
   endfunction

   // Send one request beat. Keep valid high across back-to-back beats so it
   // never sees two assignments in one time step.
   task automatic send_slice(input svc_req_type item);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data  <= item;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic test_default_bounds();
      // Omitted start/stop in both directions, then a zero-size dimension.
      send_slice(slice_of(1'b0, 32'd0, 1'b0, 32'd0, 32'sd1, 31'd10, 32'sd3, 48'sd100));
      send_slice(slice_of(1'b0, 32'd0, 1'b0, 32'd0, -32'sd1, 31'd10, 32'sd3, 48'sd100));
      send_slice(slice_of(1'b0, 32'd0, 1'b0, 32'd0, 32'sd1, 31'd0, 32'sd7, 48'sd5));
      send_slice(slice_of(1'b0, 32'd0, 1'b0, 32'd0, -32'sd1, 31'd0, 32'sd7, 48'sd5));
      send_slice(slice_of(1'b1, 32'sd4, 1'b1, 32'sd2, -32'sd1, 31'd0, 32'sd7, 48'sd5));
   endtask

   task automatic test_negative_indices();
      // Wrap from the end, and out-of-range indices that clamp.
      send_slice(slice_of(1'b1, -32'sd3, 1'b1, -32'sd1, 32'sd1, 31'd10, 32'sd2, 48'sd0));
      send_slice(slice_of(1'b1, -32'sd1, 1'b1, -32'sd11, -32'sd2, 31'd10, 32'sd2, 48'sd0));
      send_slice(slice_of(1'b1, -32'sd100, 1'b1, 32'sd100, 32'sd3, 31'd10, -32'sd5, 48'sd50));
      send_slice(slice_of(1'b1, 32'sd100, 1'b1, -32'sd100, -32'sd3, 31'd10, -32'sd5, 48'sd50));
      send_slice(slice_of(1'b1, 32'sd7, 1'b1, 32'sd7, 32'sd1, 31'd10, 32'sd1, 48'sd9));
   endtask

   task automatic test_step_zero();
      send_slice(slice_of(1'b1, 32'sd1, 1'b1, 32'sd5, 32'sd0, 31'd10, 32'sd1, 48'sd0));
      send_slice(slice_of(1'b0, 32'hFFFF_FFFF, 1'b0, 32'h8000_0000, 32'sd0, 31'h7FFF_FFFF,
                          32'h8000_0000, 48'h8000_0000_0000));
   endtask

   task automatic test_field_extremes();
      // Largest start against smallest stop: empty, offset kept at its maximum.
      send_slice(slice_of(1'b1, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF,
                          31'h7FFF_FFFF, 32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF));
      send_slice(slice_of(1'b1, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000,
                          31'h7FFF_FFFF, 32'h8000_0000, 48'h8000_0000_0000));
      // Most negative step over the full dimension: one element, start times
      // stride runs far past 48 bits.
      send_slice(slice_of(1'b0, 32'd0, 1'b0, 32'd0, 32'h8000_0000, 31'h7FFF_FFFF,
                          32'h8000_0000, 48'd0));
      // Same walk with zero stride: offset stays at zero, stride product is zero.
      send_slice(slice_of(1'b0, 32'd0, 1'b0, 32'd0, 32'h8000_0000, 31'h7FFF_FFFF,
                          32'sd0, 48'd0));
      send_slice(slice_of(1'b1, 32'sd0, 1'b0, 32'd0, 32'h8000_0000, 31'h7FFF_FFFF,
                          32'h8000_0000, 48'd0));
      send_slice(slice_of(1'b0, 32'd0, 1'b0, 32'd0, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                          32'h7FFF_FFFF, 48'h1234_5678_9ABC));
      // Offset just over, exactly at, and under the 48-bit range.
      send_slice(slice_of(1'b1, 32'sd1, 1'b0, 32'd0, 32'sd1, 31'd5, 32'sd1,
                          48'h7FFF_FFFF_FFFF));
      send_slice(slice_of(1'b1, 32'sd1, 1'b0, 32'd0, 32'sd1, 31'd5, 32'sd1,
                          48'h7FFF_FFFF_FFFE));
      send_slice(slice_of(1'b1, 32'sd1, 1'b0, 32'd0, 32'sd1, 31'd5, -32'sd1,
                          48'h8000_0000_0000));
      // Longest possible views, both directions.
      send_slice(slice_of(1'b0, 32'd0, 1'b0, 32'd0, 32'sd1, 31'h7FFF_FFFF, 32'sd0,
                          48'sd0));
      send_slice(slice_of(1'b0, 32'd0, 1'b0, 32'd0, -32'sd1, 31'h7FFF_FFFF, 32'sd0,
                          48'sd0));
   endtask

   task automatic test_random_slices();
      svc_req_type r;
      int          dim;
      for (int n = 0; n < RANDOM_SLICES; n++) begin
         // Flip between gapped and full-rate traffic every so often.
         if (n % 150 == 0) steady_flow = ($urandom_range(0, 2) == 0);
         r.start_given = ($urandom_range(0, 3) != 0);
         r.stop_given  = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 15) == 0) begin
            // Anything goes: full-width fields.
            r.dim_len     = 31'($urandom);
            r.start_value = $urandom;
            r.stop_value  = $urandom;
         end else begin
            dim           = $urandom_range(0, 40);
            r.dim_len     = 31'(dim);
            r.start_value = pick_index(dim);
            r.stop_value  = pick_index(dim);
         end
         case ($urandom_range(0, 24))
            0:       r.step_value = 32'sd0;
            1, 2:    r.step_value = $urandom;
            default: r.step_value = ($urandom_range(0, 1) != 0) ?
                                    32'($urandom_range(1, 6)) : -32'($urandom_range(1, 6));
         endcase
         r.in_stride = ($urandom_range(0, 3) == 0) ? 32'($urandom)
                                                   : 32'($urandom_range(0, 40)) - 32'sd20;
         case ($urandom_range(0, 3))
            0:       r.base_offset = 48'({$urandom, $urandom} >> 16);
            1:       r.base_offset = 48'h7FFF_FFFF_FFFF - 48'($urandom_range(0, 300));
            2:       r.base_offset = 48'h8000_0000_0000 + 48'($urandom_range(0, 300));
            default: r.base_offset = 48'($urandom_range(0, 2000)) - 48'sd1000;
         endcase
         send_slice(r);
      end
      steady_flow = 1'b0;
   endtask

   // Stimulus sequence and end of run.
   initial begin
      req_bus.valid = 1'b0;
      req_bus.data  = '0;
      reset         = 1'b1;
      steady_flow   = 1'b0;
      error_count   = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_bounds();
      test_negative_indices();
      test_step_zero();
      test_field_extremes();
      test_random_slices();

      // Drop valid after the last beat, drain, then keep running for DRAIN_CYCLES
      // to catch any stray result.
      req_bus.valid <= 1'b0;
      while (expected_views.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

   // Result-side ready: after each result beat, draw a random stall, possibly none; none while steady_flow is set.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold      = 0;
      end else if (rsp_bus.valid && rsp_bus.ready) begin
         rsp_hold = steady_flow ? 0 : $urandom_range(0, 12);
         if (rsp_hold > 0) rsp_bus.ready <= 1'b0;
      end else if (!rsp_bus.ready) begin
         if (rsp_hold > 0) rsp_hold--;
         if (rsp_hold == 0) rsp_bus.ready <= 1'b1;
      end
   end

   // Predict on each request beat, then compare each result beat with the
   // oldest prediction.
   always @(posedge clock) begin
      svc_rsp_type want;
      svc_rsp_type got;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            expected_views.insert(expected_views.size(), predict_view(req_bus.data));
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = rsp_bus.data;
            if (expected_views.size() == 0) begin
               report_mismatch("unexpected beat, error_code", 64'(got.error_code), 64'd0);
            end else begin
               want = expected_views.pop_front();
               if (got.error_code !== want.error_code)
                  report_mismatch("error_code", 64'(got.error_code), 64'(want.error_code));
               if (got.norm_start !== want.norm_start)
                  report_mismatch("norm_start", 64'(got.norm_start), 64'(want.norm_start));
               if (got.out_length !== want.out_length)
                  report_mismatch("out_length", 64'(got.out_length), 64'(want.out_length));
               if (got.out_stride !== want.out_stride)
                  report_mismatch("out_stride", got.out_stride, want.out_stride);
               if (got.out_offset !== want.out_offset)
                  report_mismatch("out_offset", 64'(got.out_offset), 64'(want.out_offset));
            end
            result_index++;
         end
      end
   end

   // Watchdog: advance on any beat, give up after a long quiet stretch.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
         end
      end
   end

endmodule

FILE: sim.f
+incdir+src
src/svc_pkg.sv
src/svc_if.sv
src/svc_norm.sv
src/svc_div_cell.sv
src/svc_fin.sv
src/slice_view_calc.sv
tb/tb_top.sv
